// File: rtl/core/ffsa_pkg.sv
// Shared types and constants for the first-fit segment allocator.
// No dependencies; imported by the cell, fit pipeline and top level.
package ffsa_pkg;

    localparam int ADDR_W = 32;
    // Wide enough for an aligned start plus padding plus a request without wrap
    localparam int EXT_W  = 35;
    localparam int FIT_LAT = 4;

    localparam logic [ADDR_W-1:0] RESET_PAGE_SIZE = 32'd67108864;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd1;
    localparam logic [2:0] ST_NO_FIT      = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN_SEG = 3'd4;

    localparam logic [1:0] REG_PAGE_SIZE = 2'd0;
    localparam logic [1:0] REG_GRAN_LOG2 = 2'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
        logic              used;
    } seg_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROT,
        OP_WRITE,
        OP_INSERT,
        OP_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t code;
        seg_t     data;
    } cell_cmd_t;

endpackage

// File: rtl/core/ffsa_cell.sv
// One table cell: holds a single segment entry and moves it to or from
// its neighbors on rotate, insert and delete. Depends on ffsa_pkg.
module ffsa_cell #(
    parameter int MAX_SEGS = 64,
    parameter int IDX      = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ffsa_pkg::cell_cmd_t         cmd,
    input  logic [$clog2(MAX_SEGS)-1:0] cmd_idx,
    input  ffsa_pkg::seg_t              left,
    input  ffsa_pkg::seg_t              right,
    output ffsa_pkg::seg_t              ent
);
    import ffsa_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEGS);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    seg_t ent_reg;
    seg_t ent_next;

    always_comb begin
        ent_next = ent_reg;
        case (cmd.code)
            OP_ROT: begin
                ent_next = right;
            end
            OP_WRITE: begin
                if (MY_IDX == cmd_idx) ent_next = cmd.data;
            end
            OP_INSERT: begin
                if (MY_IDX > cmd_idx) ent_next = left;
                else if (MY_IDX == cmd_idx) ent_next = cmd.data;
            end
            OP_DELETE: begin
                if (MY_IDX >= cmd_idx) ent_next = right;
            end
            default: begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '{start: '0, len: RESET_PAGE_SIZE, used: 1'b0};
        end else begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule

// File: rtl/core/ffsa_fit.sv
// Four-stage fit check applied to the segment at the head of the ring: alignment,
// granule bump, last byte and padding, then granule skip and length test. Depends on ffsa_pkg.
module ffsa_fit #(
    parameter int IDX_W = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_vld,
    input  logic [IDX_W-1:0]      in_idx,
    input  ffsa_pkg::seg_t        cur,
    input  ffsa_pkg::seg_t        prev,
    input  logic [31:0]           next_start,
    input  logic                  has_prev,
    input  logic                  has_next,
    input  logic [31:0]           size,
    input  logic [4:0]            align_log2,
    input  logic [4:0]            gran_log2,
    output logic                  hit,
    output logic [IDX_W-1:0]      hit_idx,
    output logic [31:0]           hit_offset,
    output logic [31:0]           hit_start,
    output logic [31:0]           hit_len,
    output logic [31:0]           hit_total
);
    import ffsa_pkg::*;

    logic [EXT_W-1:0] amask;
    logic [EXT_W-1:0] gmask;
    logic             gran_on;
    logic [EXT_W-1:0] size_x;

    assign amask   = (EXT_W'(1) << align_log2) - EXT_W'(1);
    assign gmask   = (EXT_W'(1) << gran_log2) - EXT_W'(1);
    assign gran_on = (gran_log2 != 5'd0);
    assign size_x  = EXT_W'(size);

    // stage 1: align start, end of previous segment
    logic             s1_cand_reg, s1_cand_next;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [31:0]      s1_start_reg, s1_len_reg, s1_next_start_reg;
    logic [EXT_W-1:0] s1_p_reg, s1_p_next;
    logic [EXT_W-1:0] s1_prev_end_reg, s1_prev_end_next;
    logic             s1_has_prev_reg, s1_has_next_reg;

    assign s1_cand_next     = in_vld && !cur.used && (cur.len >= size);
    assign s1_p_next        = (EXT_W'(cur.start) + amask) & ~amask;
    assign s1_prev_end_next = EXT_W'(prev.start) + EXT_W'(prev.len) - EXT_W'(1);

    // stage 2: bump to the next granule
    logic             s2_cand_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [31:0]      s2_start_reg, s2_len_reg, s2_next_start_reg;
    logic [EXT_W-1:0] s2_p_reg, s2_p_next;
    logic             s2_has_next_reg;
    logic             bump;

    assign bump = gran_on && s1_has_prev_reg &&
                  ((s1_prev_end_reg & ~gmask) >= (s1_p_reg & ~gmask));
    assign s2_p_next = bump ? ((s1_p_reg + gmask) & ~gmask) : s1_p_reg;

    // stage 3: last byte and padding
    logic             s3_cand_reg;
    logic [IDX_W-1:0] s3_idx_reg;
    logic [31:0]      s3_start_reg, s3_len_reg, s3_next_start_reg;
    logic [EXT_W-1:0] s3_p_reg;
    logic [EXT_W-1:0] s3_end_reg, s3_end_next;
    logic [EXT_W-1:0] s3_pad_reg, s3_pad_next;
    logic             s3_has_next_reg;

    assign s3_end_next = s2_p_reg + size_x - EXT_W'(1);
    assign s3_pad_next = s2_p_reg - EXT_W'(s2_start_reg);

    // stage 4: skip test and length test
    logic             skip;
    logic [EXT_W-1:0] total_x;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [31:0]      hit_offset_reg, hit_start_reg, hit_len_reg, hit_total_reg;

    assign skip = gran_on && s3_has_next_reg &&
                  ((s3_end_reg & ~gmask) >= (EXT_W'(s3_next_start_reg) & ~gmask));
    assign total_x  = s3_pad_reg + size_x;
    assign hit_next = s3_cand_reg && !skip && (EXT_W'(s3_len_reg) >= total_x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_cand_reg <= 1'b0;
            s2_cand_reg <= 1'b0;
            s3_cand_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            s1_cand_reg <= s1_cand_next;
            s2_cand_reg <= s1_cand_reg;
            s3_cand_reg <= s2_cand_reg;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_idx_reg        <= in_idx;
        s1_start_reg      <= cur.start;
        s1_len_reg        <= cur.len;
        s1_next_start_reg <= next_start;
        s1_p_reg          <= s1_p_next;
        s1_prev_end_reg   <= s1_prev_end_next;
        s1_has_prev_reg   <= has_prev;
        s1_has_next_reg   <= has_next;

        s2_idx_reg        <= s1_idx_reg;
        s2_start_reg      <= s1_start_reg;
        s2_len_reg        <= s1_len_reg;
        s2_next_start_reg <= s1_next_start_reg;
        s2_p_reg          <= s2_p_next;
        s2_has_next_reg   <= s1_has_next_reg;

        s3_idx_reg        <= s2_idx_reg;
        s3_start_reg      <= s2_start_reg;
        s3_len_reg        <= s2_len_reg;
        s3_next_start_reg <= s2_next_start_reg;
        s3_p_reg          <= s2_p_reg;
        s3_end_reg        <= s3_end_next;
        s3_pad_reg        <= s3_pad_next;
        s3_has_next_reg   <= s2_has_next_reg;

        hit_idx_reg       <= s3_idx_reg;
        hit_offset_reg    <= s3_p_reg[31:0];
        hit_start_reg     <= s3_start_reg;
        hit_len_reg       <= s3_len_reg;
        hit_total_reg     <= total_x[31:0];
    end

    assign hit        = hit_reg;
    assign hit_idx    = hit_idx_reg;
    assign hit_offset = hit_offset_reg;
    assign hit_start  = hit_start_reg;
    assign hit_len    = hit_len_reg;
    assign hit_total  = hit_total_reg;

endmodule

// File: rtl/core/first_fit_segment_allocator_unit.sv
// Top level of the first-fit segment allocator: sequencer, ring of table
// cells and fit pipeline. Depends on ffsa_pkg, ffsa_cell and ffsa_fit.
//
//  channel | ports                      | transfer when        | content
//  --------+----------------------------+----------------------+---------------------------
//  s_      | s_tvalid s_tready s_tdata  | s_tvalid & s_tready  | cmd, size, align, handle
//          | s_tuser                    |                      |
//  m_      | m_tvalid m_tready m_tdata  | m_tvalid & m_tready  | status, offset, start,
//          |                            |                      | page_empty
//  cfg_    | cfg_valid cfg_ready        | cfg_valid & cfg_ready| register index and data
//          | cfg_index cfg_data         |                      |
//
// One item at a time. The time from transfer to result is set by one full turn of the
// cell ring past the head plus the table edit steps, and for an allocate also by the
// four fit stages.
// Reset (synchronous, aresetn low) leaves one free segment of the reset page.
// A result held by m_tready stalls the block in its response step; the next
// input is taken once that result is loaded into the output register.
module first_fit_segment_allocator_unit #(
    parameter int MAX_SEGS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // req_size[31:0], align_log2[36:32], free_block_start[68:37]
    input  logic        s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // status[2:0], alloc_offset[34:3], new_block_start[66:35],
                                   // page_empty[67]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ffsa_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEGS);
    localparam int CNT_W = $clog2(MAX_SEGS + 1);
    localparam int LAST  = MAX_SEGS - 1;
    localparam int DRN_W = $clog2(FIT_LAT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_AL_DECIDE,
        S_AL_WRITE,
        S_AL_INS,
        S_FR_DECIDE,
        S_FR_WRITE,
        S_FR_DEL1,
        S_FR_DEL2,
        S_RESP
    } state_t;

    state_t           state_reg;
    logic             cmd_reg;
    logic [31:0]      size_reg;
    logic [4:0]       al_reg;
    logic [31:0]      handle_reg;
    logic [31:0]      page_reg;
    logic [4:0]       gran_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] scan_reg;
    logic [DRN_W-1:0] drain_reg;

    logic             found_reg;
    logic             split_reg;
    logic [IDX_W-1:0] win_idx_reg;
    logic [31:0]      win_off_reg, win_start_reg, win_len_reg, win_total_reg;
    logic [31:0]      split_start_reg, split_len_reg;

    logic             fr_found_reg, fr_used_reg;
    logic [IDX_W-1:0] fr_idx_reg;
    logic [31:0]      fr_start_reg, fr_len_reg;
    logic             fr_prev_free_reg, fr_next_free_reg;
    logic [31:0]      fr_prev_start_reg, fr_next_len_reg;
    logic [31:0]      sum_reg;

    logic [2:0]       status_reg;
    logic [31:0]      off_reg, start_reg;
    logic             m_tvalid_reg;
    logic [71:0]      m_tdata_reg;

    seg_t             ents [MAX_SEGS];
    cell_cmd_t        cell_cmd;
    logic [IDX_W-1:0] cell_idx;

    logic             in_xfer, cfg_xfer, cfg_page_wr;
    logic             in_range, has_next;
    logic [33:0]      al_mask, size_rounded;
    logic             fit_hit;
    logic [IDX_W-1:0] fit_idx;
    logic [31:0]      fit_off, fit_start, fit_len, fit_total;
    logic             page_empty;
    logic [IDX_W-1:0] fr_wr_idx, fr_del_idx;

    assign s_tready    = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign in_xfer     = s_tvalid && s_tready;
    assign cfg_xfer    = cfg_valid && cfg_ready;
    assign cfg_page_wr = cfg_xfer && (cfg_index == REG_PAGE_SIZE);

    assign in_range = (CNT_W'(scan_reg) < count_reg);
    assign has_next = ((CNT_W'(scan_reg) + CNT_W'(1)) < count_reg);

    assign al_mask      = (34'd1 << al_reg) - 34'd1;
    assign size_rounded = (34'(size_reg) + al_mask) & ~al_mask;

    assign page_empty = !ents[0].used && (ents[0].len == page_reg);
    assign fr_wr_idx  = fr_prev_free_reg ? (fr_idx_reg - IDX_W'(1)) : fr_idx_reg;
    assign fr_del_idx = fr_prev_free_reg ? fr_idx_reg : (fr_idx_reg + IDX_W'(1));

    // Broadcast one table operation to every cell
    always_comb begin
        cell_cmd.code = OP_HOLD;
        cell_cmd.data = '0;
        cell_idx      = '0;
        if (cfg_page_wr) begin
            cell_cmd.code = OP_WRITE;
            cell_cmd.data = '{start: '0, len: cfg_data, used: 1'b0};
        end else begin
            case (state_reg)
                S_SCAN: begin
                    cell_cmd.code = OP_ROT;
                end
                S_AL_WRITE: begin
                    cell_cmd.code = OP_WRITE;
                    cell_cmd.data = '{start: win_start_reg, len: win_total_reg, used: 1'b1};
                    cell_idx      = win_idx_reg;
                end
                S_AL_INS: begin
                    cell_cmd.code = OP_INSERT;
                    cell_cmd.data = '{start: split_start_reg, len: split_len_reg, used: 1'b0};
                    cell_idx      = win_idx_reg + IDX_W'(1);
                end
                S_FR_WRITE: begin
                    cell_cmd.code = OP_WRITE;
                    cell_cmd.data.start = fr_prev_free_reg ? fr_prev_start_reg : fr_start_reg;
                    cell_cmd.data.len   = sum_reg +
                                          (fr_next_free_reg ? fr_next_len_reg : 32'd0);
                    cell_cmd.data.used  = 1'b0;
                    cell_idx      = fr_wr_idx;
                end
                S_FR_DEL1, S_FR_DEL2: begin
                    cell_cmd.code = OP_DELETE;
                    cell_idx      = fr_del_idx;
                end
                default: begin
                    cell_cmd.code = OP_HOLD;
                end
            endcase
        end
    end

    for (genvar k = 0; k < MAX_SEGS; k++) begin : g_cell
        localparam int L = (k == 0) ? 0 : k - 1;
        localparam int R = (k == LAST) ? 0 : k + 1;
        ffsa_cell #(
            .MAX_SEGS (MAX_SEGS),
            .IDX      (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cell_cmd),
            .cmd_idx (cell_idx),
            .left    (ents[L]),
            .right   (ents[R]),
            .ent     (ents[k])
        );
    end

    ffsa_fit #(
        .IDX_W (IDX_W)
    ) u_fit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_vld     ((state_reg == S_SCAN) && (cmd_reg == CMD_ALLOC) && in_range),
        .in_idx     (scan_reg),
        .cur        (ents[0]),
        .prev       (ents[LAST]),
        .next_start (ents[1].start),
        .has_prev   (scan_reg != '0),
        .has_next   (has_next),
        .size       (size_reg),
        .align_log2 (al_reg),
        .gran_log2  (gran_reg),
        .hit        (fit_hit),
        .hit_idx    (fit_idx),
        .hit_offset (fit_off),
        .hit_start  (fit_start),
        .hit_len    (fit_len),
        .hit_total  (fit_total)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            page_reg     <= RESET_PAGE_SIZE;
            gran_reg     <= 5'd0;
            count_reg    <= CNT_W'(1);
            scan_reg     <= '0;
            drain_reg    <= '0;
            found_reg    <= 1'b0;
            fr_found_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_page_wr) begin
                page_reg  <= cfg_data;
                count_reg <= CNT_W'(1);
            end
            if (cfg_xfer && (cfg_index == REG_GRAN_LOG2)) gran_reg <= cfg_data[4:0];

            // drop the result once taken; the response step reloads it itself
            if (m_tvalid_reg && m_tready && (state_reg != S_RESP)) m_tvalid_reg <= 1'b0;

            // keep the first hit of the walk
            if (fit_hit && !found_reg) begin
                found_reg     <= 1'b1;
                win_idx_reg   <= fit_idx;
                win_off_reg   <= fit_off;
                win_start_reg <= fit_start;
                win_len_reg   <= fit_len;
                win_total_reg <= fit_total;
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        cmd_reg      <= s_tuser;
                        size_reg     <= s_tdata[31:0];
                        al_reg       <= s_tdata[36:32];
                        handle_reg   <= s_tdata[68:37];
                        found_reg    <= 1'b0;
                        fr_found_reg <= 1'b0;
                        scan_reg     <= '0;
                        off_reg      <= '0;
                        start_reg    <= '0;
                        state_reg    <= (s_tuser == CMD_FREE) ? S_SCAN : S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (size_reg == 32'd0) begin
                        status_reg <= ST_NO_FIT;
                        state_reg  <= S_RESP;
                    end else if (size_rounded >= 34'(page_reg)) begin
                        status_reg <= ST_TOO_LARGE;
                        state_reg  <= S_RESP;
                    end else begin
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if ((cmd_reg == CMD_FREE) && !fr_found_reg && in_range &&
                        (ents[0].start == handle_reg)) begin
                        fr_found_reg      <= 1'b1;
                        fr_idx_reg        <= scan_reg;
                        fr_used_reg       <= ents[0].used;
                        fr_start_reg      <= ents[0].start;
                        fr_len_reg        <= ents[0].len;
                        fr_prev_free_reg  <= (scan_reg != '0) && !ents[LAST].used;
                        fr_prev_start_reg <= ents[LAST].start;
                        sum_reg           <= ents[LAST].len;
                        fr_next_free_reg  <= has_next && !ents[1].used;
                        fr_next_len_reg   <= ents[1].len;
                    end
                    scan_reg <= scan_reg + IDX_W'(1);
                    if (scan_reg == IDX_W'(LAST)) begin
                        drain_reg <= '0;
                        state_reg <= (cmd_reg == CMD_FREE) ? S_FR_DECIDE : S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    drain_reg <= drain_reg + DRN_W'(1);
                    if (drain_reg == DRN_W'(FIT_LAT - 1)) state_reg <= S_AL_DECIDE;
                end
                S_AL_DECIDE: begin
                    split_reg <= (win_len_reg > win_total_reg);
                    if (!found_reg) begin
                        status_reg <= ST_NO_FIT;
                        state_reg  <= S_RESP;
                    end else if ((win_len_reg > win_total_reg) &&
                                 (count_reg >= CNT_W'(MAX_SEGS))) begin
                        status_reg <= ST_TABLE_FULL;
                        state_reg  <= S_RESP;
                    end else begin
                        status_reg <= ST_OK;
                        off_reg    <= win_off_reg;
                        start_reg  <= win_start_reg;
                        state_reg  <= S_AL_WRITE;
                    end
                end
                S_AL_WRITE: begin
                    split_start_reg <= win_start_reg + win_total_reg;
                    split_len_reg   <= win_len_reg - win_total_reg;
                    state_reg       <= split_reg ? S_AL_INS : S_RESP;
                end
                S_AL_INS: begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_RESP;
                end
                S_FR_DECIDE: begin
                    if (!fr_found_reg || !fr_used_reg) begin
                        status_reg <= ST_UNKNOWN_SEG;
                        state_reg  <= S_RESP;
                    end else begin
                        status_reg <= ST_OK;
                        sum_reg    <= (fr_prev_free_reg ? sum_reg : 32'd0) + fr_len_reg;
                        state_reg  <= S_FR_WRITE;
                    end
                end
                S_FR_WRITE: begin
                    state_reg <= (fr_prev_free_reg || fr_next_free_reg) ? S_FR_DEL1 : S_RESP;
                end
                S_FR_DEL1: begin
                    count_reg <= count_reg - CNT_W'(1);
                    state_reg <= (fr_prev_free_reg && fr_next_free_reg) ? S_FR_DEL2 : S_RESP;
                end
                S_FR_DEL2: begin
                    count_reg <= count_reg - CNT_W'(1);
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, page_empty, start_reg, off_reg, status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (count_reg <= CNT_W'(MAX_SEGS)))
        else $error("segment count out of range");

    a_split_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_AL_INS) && !cfg_page_wr |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("split did not add one segment");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result raised outside response step");

    a_second_delete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FR_DEL2) |-> $past(state_reg) == S_FR_DEL1)
        else $error("double merge out of order");
`endif

endmodule
